// File: rtl/cbar_pkg.sv
// Shared types, register codes and constants for the colour bar test pattern.
// No dependencies; every other file in the project imports this package.
package cbar_pkg;

	// Register port and register widths
	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = 16;
	localparam int DIM_BITS      = 13;
	localparam int PHASE_BITS    = 16;
	localparam int RGB_BITS      = 24;

	// Register indexes
	localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_ANIM_PHASE   = 2'd2;

	// Register reset values
	localparam logic [DIM_BITS-1:0]   WIDTH_RESET  = 13'd1920;
	localparam logic [DIM_BITS-1:0]   HEIGHT_RESET = 13'd1080;
	localparam logic [PHASE_BITS-1:0] PHASE_RESET  = 16'd0;

	// Geometry divisors
	localparam int BOX_DIVISOR  = 12;
	localparam int BAND_DIVISOR = 24;
	localparam int TALL_DIVISOR = 10;

	// Constant divisions by reciprocal multiplication, exact for 13-bit operands:
	// w/12 = (w>>2)/3, h/24 = (h>>3)/3, h/10 = (h>>1)/5
	localparam int BOX_PRE_SHIFT  = 2;
	localparam int BAND_PRE_SHIFT = 3;
	localparam int TALL_PRE_SHIFT = 1;
	localparam int RECIP_BITS     = 12;
	localparam logic [RECIP_BITS-1:0] RECIP3 = 12'd2731;
	localparam int RECIP3_SHIFT   = 13;
	localparam logic [RECIP_BITS-1:0] RECIP5 = 12'd3277;
	localparam int RECIP5_SHIFT   = 14;
	localparam int RMUL_BITS      = DIM_BITS + RECIP_BITS;

	// Widths of the derived geometry values
	localparam int BOX_BITS  = 10;
	localparam int BAND_BITS = 9;
	localparam int TALL_BITS = 10;
	localparam int PROD_BITS = PHASE_BITS + BOX_BITS;
	localparam int THR_BITS  = 16;

	// Divider sequencing: a load, PROD_BITS steps, then a capture of the remainder
	localparam int DIV_CNT_BITS = 5;
	localparam logic [DIV_CNT_BITS-1:0] DIV_STEP_LAST = DIV_CNT_BITS'(PROD_BITS);
	localparam logic [DIV_CNT_BITS-1:0] DIV_LAST_CNT  = DIV_CNT_BITS'(PROD_BITS + 1);

	// Bars and checker
	localparam int BAR_COUNT    = 8;
	localparam int BAR_IDX_BITS = 3;
	localparam int CHECK_BIT    = 5;

	typedef logic [RGB_BITS-1:0] rgb_t;

	localparam rgb_t WHITE = 24'hffffff;
	localparam rgb_t BLACK = 24'h000000;

	localparam rgb_t BAR_COLOUR [BAR_COUNT] = '{
		24'hffffff, 24'hffff00, 24'h00ffff, 24'h00ff00,
		24'hff00ff, 24'hff0000, 24'h0000ff, 24'h101010
	};

	// Geometry sequencer states
	typedef enum logic [2:0] {
		CAL_BOX,
		CAL_BAND,
		CAL_TALL,
		CAL_MUL,
		CAL_LEFT,
		CAL_FIN,
		CAL_READY
	} cal_state_t;

	// Per-pixel region flags handed from the compare stage to the colour stage
	typedef struct packed {
		logic                   in_frame;
		logic                   band_hit;
		logic                   box_hit;
		logic                   check_on;
		logic [BAR_COUNT-2:0]   bar_ge;
	} pix_flags_t;

endpackage

// File: rtl/cbar_if.sv
// Valid/ready stream interfaces: pixel coordinates in, RGB pixels out.
// Depends on cbar_pkg for the colour width.
interface cbar_coord_if #(parameter int COORD_BITS = 12);
	logic                  valid;
	logic                  ready;
	logic [COORD_BITS-1:0] pixel_x;
	logic [COORD_BITS-1:0] pixel_y;

	modport source (output valid, output pixel_x, output pixel_y, input ready);
	modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface cbar_pixel_if;
	import cbar_pkg::*;
	logic valid;
	logic ready;
	rgb_t pixel_rgb;

	modport source (output valid, output pixel_rgb, input ready);
	modport sink   (input valid, input pixel_rgb, output ready);
endinterface

// File: rtl/colour_bar_test_pattern_core.sv
// Colour bar test pattern generator: coordinate in, 24-bit RGB pixel out.
// Depends on cbar_pkg and the stream interfaces in cbar_if.sv.
//
// Usage:
//   coord carries one pixel coordinate per item, pixel returns its colour
//   (red in bits 23:16). Frame width, height and animation phase are written
//   through cfg_we/cfg_index/cfg_data while no item is in flight.
//   After reset and after every register write a geometry sequencer derives
//   box width, band height and box height by reciprocal multiplication (in
//   CAL_BOX, CAL_BAND and CAL_TALL), forms the box start product, takes its
//   remainder by the width with a bit-serial divider and finishes with the
//   region bounds and bar thresholds: coord.ready stays low until it is done.
//   The pixel path is three register stages: capture, region compares,
//   colour select. An accepted item is registered in these stages in turn,
//   and pixel.valid comes from the colour select register; one item is accepted
//   every cycle once the geometry is ready, limited otherwise by the output handshake.
//   When pixel.ready is low the last stage holds its item and the earlier
//   stages keep filling, so bubbles are squeezed out before coord.ready drops.
//   Reset empties the pipeline and restores the register defaults
//   (1920 x 1080, phase 0).
module colour_bar_test_pattern_core #(
	parameter int COORD_BITS = 12
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [cbar_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [cbar_pkg::CFG_DATA_BITS-1:0] cfg_data,
	cbar_coord_if.sink                         coord,
	cbar_pixel_if.source                       pixel
);
	import cbar_pkg::*;

	localparam int CMP_BITS = ((COORD_BITS > DIM_BITS) ? COORD_BITS : DIM_BITS) + 1;
	localparam int SCL_BITS = ((COORD_BITS + 3) > THR_BITS) ? (COORD_BITS + 3) : THR_BITS;

	// Configuration registers
	logic [DIM_BITS-1:0]   width_q;
	logic [DIM_BITS-1:0]   height_q;
	logic [PHASE_BITS-1:0] phase_q;

	// Geometry sequencer and divider
	cal_state_t               state_q, state_d;
	logic [DIV_CNT_BITS-1:0]  cnt_q;
	logic [PROD_BITS-1:0]     dvd_q;
	logic [DIM_BITS-1:0]      dsr_q;
	logic [DIM_BITS-1:0]      rem_q;
	logic [PROD_BITS-1:0]     prod_q;
	logic                     div_state, div_load, div_step, div_last, cal_ready;
	logic [PROD_BITS-1:0]     dvd_init;
	logic [DIM_BITS-1:0]      dsr_init;
	logic [DIM_BITS:0]        trial;
	logic                     take;
	logic [DIM_BITS-1:0]      rem_next;
	logic [BOX_BITS-1:0]      box_nz;
	logic [RMUL_BITS-1:0]     box_mul, band_mul, tall_mul;

	// Derived geometry
	logic [BOX_BITS-1:0]      box_q;
	logic [BAND_BITS-1:0]     band_q;
	logic [TALL_BITS-1:0]     tall_q;
	logic [DIM_BITS-1:0]      left_q;
	logic [DIM_BITS-1:0]      bottom_q;
	logic [DIM_BITS:0]        box_bot_q;
	logic [DIM_BITS:0]        right_q;
	logic [THR_BITS-1:0]      thr_q [BAR_COUNT-1];

	// Pixel pipeline
	logic                     valid_s1, valid_s2, valid_s3;
	logic                     en1, en2, en3;
	logic [COORD_BITS-1:0]    x_s1, y_s1;
	pix_flags_t               flags_s2, flags_c;
	rgb_t                     rgb_s3, rgb_c;
	logic [BAR_IDX_BITS-1:0]  bar_idx;

	// Write configuration registers, ignore unknown indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
			phase_q  <= PHASE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_FRAME_WIDTH:  width_q  <= cfg_data[DIM_BITS-1:0];
				CFG_FRAME_HEIGHT: height_q <= cfg_data[DIM_BITS-1:0];
				CFG_ANIM_PHASE:   phase_q  <= cfg_data[PHASE_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Sequencer next state: restart on any register write
	always_comb begin
		state_d = state_q;
		if (cfg_we) begin
			state_d = CAL_BOX;
		end else begin
			unique case (state_q)
				CAL_BOX:   state_d = CAL_BAND;
				CAL_BAND:  state_d = CAL_TALL;
				CAL_TALL:  state_d = CAL_MUL;
				CAL_MUL:   state_d = CAL_LEFT;
				CAL_LEFT:  if (div_last) state_d = CAL_FIN;
				CAL_FIN:   state_d = CAL_READY;
				CAL_READY: state_d = CAL_READY;
				default:   state_d = CAL_BOX;
			endcase
		end
	end

	// Sequencer outputs: divider phases and operands
	always_comb begin
		div_state = (state_q == CAL_LEFT);
		div_load  = div_state && (cnt_q == '0);
		div_step  = div_state && (cnt_q != '0) && (cnt_q <= DIV_STEP_LAST);
		div_last  = div_state && (cnt_q == DIV_LAST_CNT);
		cal_ready = (state_q == CAL_READY);
		unique case (state_q)
			CAL_LEFT: begin
				dvd_init = prod_q;
				dsr_init = width_q;
			end
			default: begin
				dvd_init = '0;
				dsr_init = '0;
			end
		endcase
	end

	// Constant divisions for box width, band height and box height
	always_comb begin
		box_mul  = RMUL_BITS'(width_q >> BOX_PRE_SHIFT) * RMUL_BITS'(RECIP3);
		band_mul = RMUL_BITS'(height_q >> BAND_PRE_SHIFT) * RMUL_BITS'(RECIP3);
		tall_mul = RMUL_BITS'(height_q >> TALL_PRE_SHIFT) * RMUL_BITS'(RECIP5);
	end

	// Restoring divider step: one quotient bit per cycle
	always_comb begin
		trial    = {rem_q, dvd_q[PROD_BITS-1]};
		take     = trial >= {1'b0, dsr_q};
		rem_next = take ? DIM_BITS'(trial - {1'b0, dsr_q}) : trial[DIM_BITS-1:0];
		box_nz   = (box_q != '0) ? box_q : BOX_BITS'(1);
	end

	// Hold sequencer state and step count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CAL_BOX;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we || (state_d != state_q)) begin
				cnt_q <= '0;
			end else if (div_state && !div_last) begin
				cnt_q <= cnt_q + DIV_CNT_BITS'(1);
			end
		end
	end

	// Divider datapath and derived geometry capture
	always_ff @(posedge clk) begin
		if (div_load) begin
			dvd_q <= dvd_init;
			dsr_q <= dsr_init;
			rem_q <= '0;
		end else if (div_step) begin
			dvd_q <= {dvd_q[PROD_BITS-2:0], take};
			rem_q <= rem_next;
		end
		if (div_last) begin
			left_q <= rem_q;
		end
		if (state_q == CAL_BOX) begin
			box_q <= box_mul[RECIP3_SHIFT +: BOX_BITS];
		end
		if (state_q == CAL_BAND) begin
			band_q <= band_mul[RECIP3_SHIFT +: BAND_BITS];
		end
		if (state_q == CAL_TALL) begin
			tall_q <= tall_mul[RECIP5_SHIFT +: TALL_BITS];
		end
		if (state_q == CAL_MUL) begin
			prod_q <= PROD_BITS'(phase_q) * PROD_BITS'(box_nz);
		end
		if (state_q == CAL_FIN) begin
			bottom_q  <= height_q - DIM_BITS'(band_q);
			box_bot_q <= (DIM_BITS+1)'(height_q[DIM_BITS-1:1]) + (DIM_BITS+1)'(tall_q);
			right_q   <= (DIM_BITS+1)'(left_q) + (DIM_BITS+1)'(box_q);
			for (int k = 0; k < BAR_COUNT - 1; k++) begin
				thr_q[k] <= THR_BITS'(width_q) * THR_BITS'(k + 1);
			end
		end
	end

	// Stage enables: advance a stage when it is empty or its successor moves
	assign en3 = !valid_s3 || pixel.ready;
	assign en2 = !valid_s2 || en3;
	assign en1 = !valid_s1 || en2;
	assign coord.ready = en1 && cal_ready;

	// Stage 2 compares: frame, bar thresholds, bands, box, checker phase
	always_comb begin
		logic [CMP_BITS-1:0] xe, ye;
		logic [SCL_BITS-1:0] xs;
		xe = CMP_BITS'(x_s1);
		ye = CMP_BITS'(y_s1);
		xs = SCL_BITS'({x_s1, 3'b000});
		flags_c.in_frame = (xe < CMP_BITS'(width_q)) && (ye < CMP_BITS'(height_q));
		flags_c.band_hit = (ye < CMP_BITS'(band_q)) || (ye >= CMP_BITS'(bottom_q));
		flags_c.box_hit  = (ye >= CMP_BITS'(height_q[DIM_BITS-1:1])) &&
			(ye < CMP_BITS'(box_bot_q)) &&
			(xe >= CMP_BITS'(left_q)) && (xe < CMP_BITS'(right_q));
		flags_c.check_on = x_s1[CHECK_BIT] ^ phase_q[0];
		for (int k = 0; k < BAR_COUNT - 1; k++) begin
			flags_c.bar_ge[k] = xs >= SCL_BITS'(thr_q[k]);
		end
	end

	// Stage 3 colour: box over checker bands over bars, black outside
	always_comb begin
		bar_idx = '0;
		for (int k = 0; k < BAR_COUNT - 1; k++) begin
			bar_idx = bar_idx + BAR_IDX_BITS'(flags_s2.bar_ge[k]);
		end
		priority if (!flags_s2.in_frame) begin
			rgb_c = BLACK;
		end else if (flags_s2.box_hit) begin
			rgb_c = WHITE;
		end else if (flags_s2.band_hit) begin
			rgb_c = flags_s2.check_on ? WHITE : BLACK;
		end else begin
			rgb_c = BAR_COLOUR[bar_idx];
		end
	end

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (en1) valid_s1 <= coord.valid && cal_ready;
			if (en2) valid_s2 <= valid_s1;
			if (en3) valid_s3 <= valid_s2;
		end
	end

	// Advance payload with its item
	always_ff @(posedge clk) begin
		if (en1 && coord.valid) begin
			x_s1 <= coord.pixel_x;
			y_s1 <= coord.pixel_y;
		end
		if (en2 && valid_s1) flags_s2 <= flags_c;
		if (en3 && valid_s2) rgb_s3 <= rgb_c;
	end

	assign pixel.valid     = valid_s3;
	assign pixel.pixel_rgb = rgb_s3;

	// An item in stage 2 moves on when stage 3 opens
	a_stage_move: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && en3 |=> valid_s3)
		else $error("item lost between stage 2 and stage 3");

	// Bar threshold hits form a thermometer code
	a_bar_thermo: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (((flags_s2.bar_ge >> 1) & ~flags_s2.bar_ge) == '0))
		else $error("bar threshold flags not monotone");

	// Partial remainder stays below the divisor while dividing
	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		div_step && (dsr_q != '0) |-> (rem_q < dsr_q))
		else $error("divider remainder out of range");

	// Box start column lies inside the frame once geometry is ready
	a_left_range: assert property (@(posedge clk) disable iff (!arst_n)
		cal_ready && (width_q != '0) |-> (left_q < width_q))
		else $error("box start column beyond frame width");

endmodule
